@@ hw/rtl/u2u_pkg.sv @@
package u2u_pkg;

  localparam int unsigned ACC_W   = 21;
  localparam int unsigned REM_W   = 2;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned COUNT_W = 2;

  // Byte class masks and patterns
  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_PAT   = 8'b1000_0000;
  localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_PAT  = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_PAT  = 8'b1110_0000;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_PAT  = 8'b1111_0000;

  // Payload masks for continuation and lead bytes
  localparam logic [7:0] CONT_DATA  = 8'b0011_1111;
  localparam logic [7:0] LEAD2_DATA = 8'b0001_1111;
  localparam logic [7:0] LEAD3_DATA = 8'b0000_1111;
  localparam logic [7:0] LEAD4_DATA = 8'b0000_0111;

  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [ACC_W-1:0]  SUPP_BASE    = 21'h10000;

  localparam logic [COUNT_W-1:0] UNITS_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] UNITS_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] UNITS_PAIR = 2'd2;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [REM_W-1:0] remaining;
  } u2u_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] unit_count;
    logic [UNIT_W-1:0]  first_unit;
    logic [UNIT_W-1:0]  second_unit;
    logic               broken_sequence;
    logic               end_marker;
  } u2u_result_t;

endpackage

@@ hw/rtl/u2u_ifs.sv @@
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  unit_count;
  logic [15:0] first_unit;
  logic [15:0] second_unit;
  logic        broken_sequence;
  logic        end_marker;

  modport source (output valid, output unit_count, output first_unit, output second_unit,
                  output broken_sequence, output end_marker, input ready);
  modport sink   (input valid, input unit_count, input first_unit, input second_unit,
                  input broken_sequence, input end_marker, output ready);
endinterface

@@ hw/rtl/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder.
//
// in_ch carries one UTF-8 byte per beat (text_byte) and a last_byte flag that
// closes the text. out_ch returns exactly one result beat per input beat:
// unit_count (0, 1 or 2), first_unit, second_unit (low surrogate of a pair),
// broken_sequence for dropped stray bytes or abandoned sequences, and
// end_marker echoing last_byte.
//
// An accepted input beat passes through the input register and then the result
// register before its result appears on out_ch. Throughput is one byte per
// cycle while out_ch.ready stays high; the decode between the two registers
// is a single pass of shallow byte-class logic and one 21-bit subtract.
// Reset (rst_n low, synchronous) empties both registers and clears the
// pending sequence. When the receiver holds out_ch.ready low, the result
// register holds, the input register fills, and in_ch.ready drops until the
// result beat is taken; no beat is lost or duplicated.
module utf8_to_utf16_transcoder
  import u2u_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  u2u_in_if.sink        in_ch,
  u2u_out_if.source     out_ch
);

  // Input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  // Sequence state and result register
  u2u_state_t  seq_r;
  u2u_state_t  seq_nxt;
  u2u_result_t res_nxt;
  u2u_result_t res_r;
  logic        out_valid_r;

  logic        advance;

  // Move the held byte into the result register when that slot is free
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  u2u_decode u_decode (
    .state_cur (seq_r),
    .text_byte (in_byte_r),
    .last_byte (in_last_r),
    .state_nxt (seq_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Payload: capture only on an accepted beat
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  // Sequence state advances exactly once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (advance) begin
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.unit_count      = res_r.unit_count;
  assign out_ch.first_unit      = res_r.first_unit;
  assign out_ch.second_unit     = res_r.second_unit;
  assign out_ch.broken_sequence = res_r.broken_sequence;
  assign out_ch.end_marker      = res_r.end_marker;

endmodule

@@ hw/rtl/u2u_decode.sv @@
module u2u_decode
  import u2u_pkg::*;
(
  input  u2u_state_t  state_cur,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output u2u_state_t  state_nxt,
  output u2u_result_t result
);

  logic [ACC_W-1:0] emit_cp;
  logic             emit_en;
  logic [ACC_W-1:0] supp_off;
  logic             seq_broken;

  // Walk one byte through the sequence tracker
  always_comb begin
    logic fresh;
    logic broken;
    logic [ACC_W-1:0] acc;
    logic [REM_W-1:0] rem;
    fresh   = 1'b1;
    broken  = 1'b0;
    acc     = state_cur.acc;
    rem     = state_cur.remaining;
    emit_en = 1'b0;
    emit_cp = '0;

    if (rem != '0) begin
      if ((text_byte & CONT_MASK) == CONT_PAT) begin
        fresh = 1'b0;
        acc   = {acc[ACC_W-7:0], text_byte[5:0] & CONT_DATA[5:0]};
        rem   = rem - REM_W'(1);
        if (rem == '0) begin
          emit_en = 1'b1;
          emit_cp = acc;
          acc     = '0;
        end
      end else begin
        // drop the pending sequence, restart at this byte
        broken = 1'b1;
        rem    = '0;
        acc    = '0;
      end
    end

    if (fresh) begin
      if ((text_byte & ASCII_MASK) == '0) begin
        emit_en = 1'b1;
        emit_cp = ACC_W'(text_byte);
      end else if ((text_byte & LEAD2_MASK) == LEAD2_PAT) begin
        acc = ACC_W'(text_byte & LEAD2_DATA);
        rem = REM_W'(1);
      end else if ((text_byte & LEAD3_MASK) == LEAD3_PAT) begin
        acc = ACC_W'(text_byte & LEAD3_DATA);
        rem = REM_W'(2);
      end else if ((text_byte & LEAD4_MASK) == LEAD4_PAT) begin
        acc = ACC_W'(text_byte & LEAD4_DATA);
        rem = REM_W'(3);
      end else begin
        broken = 1'b1;
      end
    end

    if (last_byte && rem != '0) begin
      broken = 1'b1;
      rem    = '0;
      acc    = '0;
    end

    state_nxt.acc       = acc;
    state_nxt.remaining = rem;
    seq_broken          = broken;
  end

  assign supp_off = emit_cp - SUPP_BASE;

  // Build the UTF-16 unit or surrogate pair
  always_comb begin
    result.unit_count      = UNITS_NONE;
    result.first_unit      = '0;
    result.second_unit     = '0;
    result.broken_sequence = seq_broken;
    result.end_marker      = last_byte;
    if (emit_en) begin
      if (emit_cp[ACC_W-1:UNIT_W] != '0) begin
        result.unit_count  = UNITS_PAIR;
        result.first_unit  = HI_SURR_BASE + UNIT_W'(supp_off[ACC_W-1:10]);
        result.second_unit = LO_SURR_BASE + UNIT_W'(supp_off[9:0]);
      end else begin
        result.unit_count  = UNITS_ONE;
        result.first_unit  = emit_cp[UNIT_W-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/u2u_checker.sv @@
module u2u_checker
  import u2u_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] unit_count,
  input logic [UNIT_W-1:0]  first_unit,
  input logic [UNIT_W-1:0]  second_unit,
  input logic               broken_sequence,
  input logic               end_marker
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(unit_count) && $stable(first_unit)
      && $stable(second_unit) && $stable(broken_sequence) && $stable(end_marker))
    else $error("result beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> unit_count == UNITS_NONE || unit_count == UNITS_ONE
      || unit_count == UNITS_PAIR)
    else $error("unit_count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_count == UNITS_NONE |-> first_unit == '0 && second_unit == '0)
    else $error("units present with zero count");

  a_low_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_count == UNITS_PAIR |-> second_unit[15:10] == 6'b110111)
    else $error("second unit of a pair is not a low surrogate");

  a_single_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unit_count == UNITS_ONE |-> second_unit == '0)
    else $error("second unit set for a single unit");

endmodule

bind utf8_to_utf16_transcoder u2u_checker u_u2u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .unit_count      (out_ch.unit_count),
  .first_unit      (out_ch.first_unit),
  .second_unit     (out_ch.second_unit),
  .broken_sequence (out_ch.broken_sequence),
  .end_marker      (out_ch.end_marker)
);
